FILE: sv/mmft_pkg.sv
// ----------------------------------------------------------------------------
// Multi-turn motor feedback tracker package
// Shared widths, reset values, unwrap limits, the fixed-point scaling
// constants and the transaction type passed from the state stage to the
// scaling pipeline.
// ----------------------------------------------------------------------------
package mmft_pkg;

	// Field widths.
	localparam int ID_W     = 11;
	localparam int ANGLE_W  = 16;
	localparam int TURN_W   = 18;
	localparam int TOTAL_W  = 32;
	localparam int SHAFT_W  = 31;
	localparam int SPEED_W  = 12;

	// Identifier of motor zero after reset.
	localparam logic [ID_W-1:0] BASE_ID_RESET = 11'd513;

	// Unwrap thresholds and saturation limits of the turn count.
	localparam logic signed [ANGLE_W:0]   HALF_TURN = 17'sd4096;
	localparam logic signed [TURN_W-1:0]  TURN_MAX  = 18'sh1ffff;
	localparam logic signed [TURN_W-1:0]  TURN_MIN  = 18'sh20000;

	// Shaft angle: q = |total| * 935 / 1596, split as total = 1596*h + r.
	// h uses a 2^-42 scaled reciprocal, exact for 31-bit magnitudes.
	localparam logic [31:0] SHAFT_RECIP = 32'd2755668241;
	localparam logic [10:0] SHAFT_DIV   = 11'd1596;
	localparam logic [9:0]  SHAFT_NUM   = 10'd935;
	// 935 * ceil(2^32 / 1596): gives floor(935*r/1596) exactly for r < 1596.
	localparam logic [31:0] SHAFT_FRAC  = 32'd2516162605;
	// 187 * ceil(2^35 / 3591): gives floor(|speed|*187/3591) exactly.
	localparam logic [30:0] SPEED_COEF  = 31'd1789270791;

	// One tracked frame after the state update.
	typedef struct packed {
		logic [1:0]                motor;
		logic signed [TOTAL_W-1:0] total;
		logic signed [15:0]        speed;
		logic signed [15:0]        torque;
		logic [7:0]                temp;
	} mmft_item_t;

endpackage

FILE: sv/mmft_state.sv
// ----------------------------------------------------------------------------
// Motor state stage
// Matches the frame identifier, reads the motor's entry from a synchronous
// state memory, unwraps the angle into a saturating turn count, forms the
// total angle and writes the entry back. The most recent write is forwarded
// to a read that was issued at the same clock edge.
// ----------------------------------------------------------------------------
module mmft_state
	import mmft_pkg::*;
#(
	parameter int MOTOR_COUNT = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [ID_W-1:0]           base_id,
	input  logic                      frame_valid,
	output logic                      frame_ready,
	input  logic [ID_W-1:0]           frame_id,
	input  logic [ANGLE_W-1:0]        angle_raw,
	input  logic signed [15:0]        speed_raw,
	input  logic signed [15:0]        torque_raw,
	input  logic [7:0]                temperature_raw,
	output logic                      item_valid,
	input  logic                      item_ready,
	output mmft_item_t                item
);

	localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	typedef struct packed {
		logic [ANGLE_W-1:0]       prev_angle;
		logic signed [TURN_W-1:0] turn_count;
		logic [ANGLE_W-1:0]       angle_offset;
	} entry_t;

	// State memory, registered read port, forwarding register.
	entry_t                 mem [MOTOR_COUNT];
	entry_t                 rd_q;
	entry_t                 fwd_q;
	logic [IDX_W-1:0]       fwd_idx_q;
	logic                   fwd_vld_q;
	logic [MOTOR_COUNT-1:0] taken_q;

	// Stage 1 registers.
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [ANGLE_W-1:0]     angle_s1;
	logic signed [15:0]     speed_s1;
	logic signed [15:0]     torque_s1;
	logic [7:0]             temp_s1;

	logic [ID_W:0]          rel;
	logic                   hit;
	logic [IDX_W-1:0]       rd_idx;
	logic                   accept;
	logic                   rd_en;
	logic                   wr_en;
	logic                   use_fwd;
	logic                   taken;
	entry_t                 cur;
	entry_t                 wr_data;
	logic signed [ANGLE_W:0] diff;
	logic signed [TURN_W-1:0] turn_next;
	logic signed [TOTAL_W-1:0] total;
	logic [IDX_W+1:0]       idx_ext;

	// Identifier match against base_id .. base_id+MOTOR_COUNT-1, no wrap.
	always_comb begin
		rel    = {1'b0, frame_id} - {1'b0, base_id};
		hit    = !rel[ID_W] && (rel[ID_W-1:0] < ID_W'(MOTOR_COUNT));
		rd_idx = rel[IDX_W-1:0];
	end

	assign frame_ready = !vld_s1 || item_ready;
	assign accept      = frame_valid && frame_ready;
	assign rd_en       = accept && hit;
	assign wr_en       = vld_s1 && item_ready;

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (frame_ready) begin
			vld_s1 <= frame_valid && hit;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_s1    <= rd_idx;
			angle_s1  <= angle_raw;
			speed_s1  <= speed_raw;
			torque_s1 <= torque_raw;
			temp_s1   <= temperature_raw;
		end
	end

	// State memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_s1] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx];
		end
	end

	// The forwarding register always holds the newest write of any entry.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_q     <= wr_data;
			fwd_idx_q <= idx_s1;
		end
	end

	// Offset-captured flags double as entry valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
			taken_q   <= '0;
		end else if (wr_en) begin
			fwd_vld_q       <= 1'b1;
			taken_q[idx_s1] <= 1'b1;
		end
	end

	// Read-modify-write of the entry.
	always_comb begin
		use_fwd = fwd_vld_q && (fwd_idx_q == idx_s1);
		taken   = taken_q[idx_s1];
		if (!taken) begin
			cur = '0;
		end else if (use_fwd) begin
			cur = fwd_q;
		end else begin
			cur = rd_q;
		end

		diff = signed'({1'b0, angle_s1}) - signed'({1'b0, cur.prev_angle});
		turn_next = cur.turn_count;
		if (diff > HALF_TURN) begin
			if (cur.turn_count != TURN_MIN) begin
				turn_next = cur.turn_count - 18'sd1;
			end
		end else if (diff < -HALF_TURN) begin
			if (cur.turn_count != TURN_MAX) begin
				turn_next = cur.turn_count + 18'sd1;
			end
		end

		total = signed'({turn_next[TURN_W-1], turn_next, 13'b0})
			+ signed'({16'b0, angle_s1}) - signed'({16'b0, cur.angle_offset});

		wr_data.prev_angle = angle_s1;
		if (taken) begin
			wr_data.turn_count   = turn_next;
			wr_data.angle_offset = cur.angle_offset;
		end else begin
			wr_data.turn_count   = '0;
			wr_data.angle_offset = angle_s1;
		end

		idx_ext     = (IDX_W+2)'(idx_s1);
		item.motor  = idx_ext[1:0];
		item.total  = total;
		item.speed  = speed_s1;
		item.torque = torque_s1;
		item.temp   = temp_s1;
	end

	assign item_valid = vld_s1;

	// A write marks its entry as captured.
	a_write_sets_taken: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> taken_q[$past(idx_s1)])
		else $error("write did not set the captured flag");

	// Captured flags never clear outside reset.
	a_taken_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (($past(taken_q) & ~taken_q) == '0))
		else $error("captured flag cleared");

	// A stalled frame keeps its motor index.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !item_ready) |=> (vld_s1 && $stable(idx_s1)))
		else $error("stalled frame changed");

endmodule

FILE: sv/mmft_scale.sv
// ----------------------------------------------------------------------------
// Scaling pipeline
// Converts the total angle into output-shaft degrees in Q8 and the rotor
// speed into shaft speed, both truncated toward zero, using constant
// reciprocal multiplies. Each stage holds its transaction under backpressure.
// ----------------------------------------------------------------------------
module mmft_scale
	import mmft_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  mmft_item_t                item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [1:0]                motor_index,
	output logic signed [TOTAL_W-1:0] total_angle,
	output logic signed [SHAFT_W-1:0] shaft_angle_q8,
	output logic signed [SPEED_W-1:0] shaft_speed,
	output logic signed [15:0]        torque_echo,
	output logic [7:0]                temperature_echo
);

	logic       vld_s2, vld_s3, vld_s4, vld_s5, vld_q;
	logic       adv2, adv3, adv4, adv5, adv_out;
	mmft_item_t item_s2, item_s3, item_s4, item_s5;

	logic [30:0] u_s3, u_s4;
	logic        tneg_s3, tneg_s4, tneg_s5;
	logic [15:0] sabs_s3;
	logic        sneg_s3, sneg_s4, sneg_s5;
	logic [20:0] h_s4;
	logic [10:0] spq_s4, spq_s5;
	logic [10:0] r_s5;
	logic [30:0] hx_s5;

	logic [TOTAL_W-1:0] tmag;
	logic [15:0]        smag;
	logic [62:0]        prod1;
	logic [46:0]        prod3;
	logic [30:0]        rem;
	logic [42:0]        prod2;
	logic [30:0]        q;

	// Backpressure chain.
	assign adv_out    = !vld_q || result_ready;
	assign adv5       = !vld_s5 || adv_out;
	assign adv4       = !vld_s4 || adv5;
	assign adv3       = !vld_s3 || adv4;
	assign adv2       = !vld_s2 || adv3;
	assign item_ready = adv2;

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (adv2) begin
				vld_s2 <= item_valid;
			end
			if (adv3) begin
				vld_s3 <= vld_s2;
			end
			if (adv4) begin
				vld_s4 <= vld_s3;
			end
			if (adv5) begin
				vld_s5 <= vld_s4;
			end
			if (adv_out) begin
				vld_q <= vld_s5;
			end
		end
	end

	// Datapath arithmetic between the stages.
	always_comb begin
		tmag  = item_s2.total[TOTAL_W-1] ? (TOTAL_W'(0) - item_s2.total) : item_s2.total;
		smag  = item_s2.speed[15] ? (16'd0 - item_s2.speed) : item_s2.speed;
		prod1 = 63'(u_s3) * 63'(SHAFT_RECIP);
		prod3 = 47'(sabs_s3) * 47'(SPEED_COEF);
		rem   = u_s4 - 31'(h_s4) * 31'(SHAFT_DIV);
		prod2 = 43'(r_s5) * 43'(SHAFT_FRAC);
		q     = hx_s5 + 31'(prod2[41:32]);
	end

	// Stage 2: input register.
	always_ff @(posedge clk) begin
		if (adv2 && item_valid) begin
			item_s2 <= item;
		end
	end

	// Stage 3: magnitudes and signs.
	always_ff @(posedge clk) begin
		if (adv3 && vld_s2) begin
			item_s3 <= item_s2;
			u_s3    <= tmag[30:0];
			tneg_s3 <= item_s2.total[TOTAL_W-1];
			sabs_s3 <= smag;
			sneg_s3 <= item_s2.speed[15];
		end
	end

	// Stage 4: reciprocal multiplies.
	always_ff @(posedge clk) begin
		if (adv4 && vld_s3) begin
			item_s4 <= item_s3;
			u_s4    <= u_s3;
			h_s4    <= prod1[62:42];
			tneg_s4 <= tneg_s3;
			spq_s4  <= prod3[45:35];
			sneg_s4 <= sneg_s3;
		end
	end

	// Stage 5: remainder and whole-part product.
	always_ff @(posedge clk) begin
		if (adv5 && vld_s4) begin
			item_s5 <= item_s4;
			r_s5    <= rem[10:0];
			hx_s5   <= 31'(h_s4) * 31'(SHAFT_NUM);
			tneg_s5 <= tneg_s4;
			spq_s5  <= spq_s4;
			sneg_s5 <= sneg_s4;
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (adv_out && vld_s5) begin
			motor_index      <= item_s5.motor;
			total_angle      <= item_s5.total;
			shaft_angle_q8   <= tneg_s5 ? (31'd0 - q) : q;
			shaft_speed      <= sneg_s5 ? (12'd0 - 12'(spq_s5)) : 12'(spq_s5);
			torque_echo      <= item_s5.torque;
			temperature_echo <= item_s5.temp;
		end
	end

	assign result_valid = vld_q;

	// Geared speed stays within the range a 16-bit rpm word allows.
	a_speed_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> ((shaft_speed <= 12'sd1707) && (shaft_speed >= -12'sd1707)))
		else $error("shaft speed out of range");

	// A negative shaft angle only comes from a negative total angle.
	a_shaft_sign: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q |-> !(shaft_angle_q8[SHAFT_W-1] && !total_angle[TOTAL_W-1]))
		else $error("shaft angle sign disagrees with total angle");

endmodule

FILE: sv/multiturn_motor_feedback_tracker.sv
// ----------------------------------------------------------------------------
// Multi-turn motor feedback tracker
// Unwraps decoded motor feedback frames into per-motor turn counts and
// reports total angle, output-shaft angle and shaft speed.
// ----------------------------------------------------------------------------
// A frame passes the state stage, scaling stages 2 to 5 and the output register.
// Throughput: one frame per cycle unless result_ready stalls; the state memory
// read-modify-write with forwarding of the last write lets the same motor repeat back to back.
// Frames outside the motor identifier range are accepted and give no result.
// Reset clears all offset-captured flags and sets base_id to 513.
// ----------------------------------------------------------------------------
module multiturn_motor_feedback_tracker
	import mmft_pkg::*;
#(
	parameter int MOTOR_COUNT = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [ID_W-1:0]           cfg_wdata,
	input  logic                      frame_valid,
	output logic                      frame_ready,
	input  logic [ID_W-1:0]           frame_id,
	input  logic [ANGLE_W-1:0]        angle_raw,
	input  logic signed [15:0]        speed_raw,
	input  logic signed [15:0]        torque_raw,
	input  logic [7:0]                temperature_raw,
	output logic                      result_valid,
	input  logic                      result_ready,
	output logic [1:0]                motor_index,
	output logic signed [TOTAL_W-1:0] total_angle,
	output logic signed [SHAFT_W-1:0] shaft_angle_q8,
	output logic signed [SPEED_W-1:0] shaft_speed,
	output logic signed [15:0]        torque_echo,
	output logic [7:0]                temperature_echo
);

	logic [ID_W-1:0] base_id_q;
	logic            item_valid;
	logic            item_ready;
	mmft_item_t      item;

	// Base identifier register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_id_q <= BASE_ID_RESET;
		end else if (cfg_we) begin
			base_id_q <= cfg_wdata;
		end
	end

	// Per-motor state and angle unwrap.
	mmft_state #(
		.MOTOR_COUNT(MOTOR_COUNT)
	) u_state (
		.clk            (clk),
		.arst_n         (arst_n),
		.base_id        (base_id_q),
		.frame_valid    (frame_valid),
		.frame_ready    (frame_ready),
		.frame_id       (frame_id),
		.angle_raw      (angle_raw),
		.speed_raw      (speed_raw),
		.torque_raw     (torque_raw),
		.temperature_raw(temperature_raw),
		.item_valid     (item_valid),
		.item_ready     (item_ready),
		.item           (item)
	);

	// Shaft angle and speed scaling.
	mmft_scale u_scale (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (item_valid),
		.item_ready      (item_ready),
		.item            (item),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.motor_index     (motor_index),
		.total_angle     (total_angle),
		.shaft_angle_q8  (shaft_angle_q8),
		.shaft_speed     (shaft_speed),
		.torque_echo     (torque_echo),
		.temperature_echo(temperature_echo)
	);

endmodule
